// ----- hdl/tcf_pkg.sv -----
// Shared widths, reset values and codes for the timed color crossfader.
// No dependencies; compile first.
package tcf_pkg;

  localparam int COLOR_W    = 24;
  localparam int CHAN_W     = 8;
  localparam int NUM_CHAN   = 3;
  localparam int DUR_W      = 16;
  localparam int ELAPSED_W  = 17;
  localparam int PROD_W     = CHAN_W + DUR_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  localparam logic [DUR_W-1:0] DUR_RESET        = 16'd1000;
  localparam logic [DUR_W-1:0] MIN_UPDATE_RESET = 16'd100;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_TARGET = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FADE_DURATION       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_UPDATE_INTERVAL = 1'd1;

endpackage

// ----- hdl/tcf_req_if.sv -----
// Request channel of the crossfader: tick or offered target color.
// Depends on tcf_pkg.
interface tcf_req_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [tcf_pkg::COLOR_W-1:0] target_color;

  modport source (output valid, operation, target_color, input ready);
  modport sink   (input valid, operation, target_color, output ready);
endinterface

// ----- hdl/tcf_res_if.sv -----
// Result channel of the crossfader: shown color and target-taken flag.
// Depends on tcf_pkg.
interface tcf_res_if;
  logic                        valid;
  logic                        ready;
  logic [tcf_pkg::COLOR_W-1:0] shown_color;
  logic                        target_taken;

  modport source (output valid, shown_color, target_taken, input ready);
  modport sink   (input valid, shown_color, target_taken, output ready);
endinterface

// ----- hdl/timed_color_crossfader.sv -----
// Timed RGB crossfader: one shared multiplier and one shared compare/subtract
// unit, sequenced per color channel. Depends on tcf_pkg, tcf_req_if, tcf_res_if.
//
//   channel | role     | payload
//   --------+----------+-------------------------------------------
//   req     | sink     | operation, target_color
//   res     | source   | shown_color, target_taken
//   cfg_*   | write    | cfg_we, cfg_index, cfg_data (no read-back)
//
// A tick inside the fade runs, per channel, the multiply states MUL0 and MUL1
// and eight restoring-division steps on the shared unit, then DONE.
// A tick past the fade and a target offer go straight from accept to DONE.
// Synchronous reset (rst) blacks fade and present colors, clears elapsed ticks.
// req.ready is low while an item is in work; a stalled result holds in the
// output register and the next request is still taken.
module timed_color_crossfader (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcf_pkg::CFG_DATA_W-1:0] cfg_data,
  tcf_req_if.sink                        req,
  tcf_res_if.source                      res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state;

  logic [tcf_pkg::DUR_W-1:0]     fade_duration;
  logic [tcf_pkg::DUR_W-1:0]     min_update_interval;
  logic [tcf_pkg::COLOR_W-1:0]   fade_start_color;
  logic [tcf_pkg::COLOR_W-1:0]   fade_end_color;
  logic [tcf_pkg::COLOR_W-1:0]   present_color;
  logic [tcf_pkg::ELAPSED_W-1:0] elapsed_ticks;

  logic [tcf_pkg::PROD_W-1:0]    acc;
  logic [tcf_pkg::PROD_W-2:0]    divs;
  logic [tcf_pkg::CHAN_W-1:0]    quot;
  logic [2:0]                    bit_cnt;
  logic [1:0]                    ch;
  logic                          taken;

  logic                          out_valid;
  logic [tcf_pkg::COLOR_W-1:0]   out_color;
  logic                          out_taken;

  logic                          accept;
  logic [tcf_pkg::ELAPSED_W-1:0] elapsed_next;
  logic                          past_fade;
  logic [tcf_pkg::CHAN_W-1:0]    chan_s;
  logic [tcf_pkg::CHAN_W-1:0]    chan_e;
  logic [tcf_pkg::CHAN_W-1:0]    mul_a;
  logic [tcf_pkg::DUR_W-1:0]     mul_b;
  logic [tcf_pkg::PROD_W-1:0]    prod;
  logic                          div_ge;
  logic [tcf_pkg::PROD_W-1:0]    acc_sub;
  logic [tcf_pkg::CHAN_W-1:0]    quot_next;

  assign accept = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);

  assign res.valid        = out_valid;
  assign res.shown_color  = out_color;
  assign res.target_taken = out_taken;

  assign elapsed_next = (elapsed_ticks == tcf_pkg::ELAPSED_MAX) ? elapsed_ticks
                        : elapsed_ticks + 1'b1;
  assign past_fade = (fade_duration == '0) ||
                     (elapsed_next > {1'b0, fade_duration});

  always_comb begin
    case (ch)
      2'd0:    begin
        chan_s = fade_start_color[7:0];
        chan_e = fade_end_color[7:0];
      end
      2'd1:    begin
        chan_s = fade_start_color[15:8];
        chan_e = fade_end_color[15:8];
      end
      default: begin
        chan_s = fade_start_color[23:16];
        chan_e = fade_end_color[23:16];
      end
    endcase
  end

  // Shared multiplier: start*(D-t) first, then end*t.
  assign mul_a = (state == ST_MUL0) ? chan_s : chan_e;
  assign mul_b = (state == ST_MUL0) ? fade_duration - elapsed_ticks[tcf_pkg::DUR_W-1:0]
                                    : elapsed_ticks[tcf_pkg::DUR_W-1:0];
  assign prod  = tcf_pkg::PROD_W'(mul_a) * tcf_pkg::PROD_W'(mul_b);

  // Shared compare/subtract for one restoring-division step.
  assign div_ge    = acc >= {1'b0, divs};
  assign acc_sub   = acc - {1'b0, divs};
  assign quot_next = {quot[tcf_pkg::CHAN_W-2:0], div_ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      out_valid           <= 1'b0;
      fade_duration       <= tcf_pkg::DUR_RESET;
      min_update_interval <= tcf_pkg::MIN_UPDATE_RESET;
      fade_start_color    <= '0;
      fade_end_color      <= '0;
      present_color       <= '0;
      elapsed_ticks       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tcf_pkg::CFG_FADE_DURATION:       fade_duration       <= cfg_data;
          tcf_pkg::CFG_MIN_UPDATE_INTERVAL: min_update_interval <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && res.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.operation == tcf_pkg::OP_TICK) begin
              taken         <= 1'b0;
              elapsed_ticks <= elapsed_next;
              if (past_fade) begin
                present_color <= fade_end_color;
                state         <= ST_DONE;
              end else begin
                ch    <= 2'd0;
                state <= ST_MUL0;
              end
            end else begin
              if (elapsed_ticks > {1'b0, min_update_interval}) begin
                fade_start_color <= present_color;
                fade_end_color   <= req.target_color;
                elapsed_ticks    <= '0;
                taken            <= 1'b1;
              end else begin
                taken <= 1'b0;
              end
              state <= ST_DONE;
            end
          end
        end
        ST_MUL0: begin
          acc   <= prod;
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          acc     <= acc + prod;
          divs    <= {fade_duration, 7'd0};
          bit_cnt <= 3'd7;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          if (div_ge) begin
            acc <= acc_sub;
          end
          quot <= quot_next;
          divs <= divs >> 1;
          if (bit_cnt == 3'd0) begin
            case (ch)
              2'd0:    present_color[7:0]   <= quot_next;
              2'd1:    present_color[15:8]  <= quot_next;
              default: present_color[23:16] <= quot_next;
            endcase
            if (ch == 2'(tcf_pkg::NUM_CHAN - 1)) begin
              state <= ST_DONE;
            end else begin
              ch    <= ch + 1'b1;
              state <= ST_MUL0;
            end
          end else begin
            bit_cnt <= bit_cnt - 1'b1;
          end
        end
        ST_DONE: begin
          if (!out_valid || res.ready) begin
            out_valid <= 1'b1;
            out_color <= present_color;
            out_taken <= taken;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request taken while an item is in work");

  a_div_remainder_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (acc < {divs, 1'b0}))
    else $error("division remainder out of range");

  a_blend_within_fade: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL0) |-> (fade_duration != '0 &&
                            elapsed_ticks <= {1'b0, fade_duration}))
    else $error("blend started outside the fade");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for timed_color_crossfader: directed table and random fade phases,
// with a built-in predictor of the RGB crossfade.
// Depends on tcf_pkg, tcf_req_if, tcf_res_if and the RTL top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcf_pkg::*;

  localparam int SETTLE      = 40;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 500;
  localparam int PHASE_ITEMS = 160;
  localparam longint LIMIT_NS = 5_000_000;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               taken;
  } shown_t;

  typedef struct packed {
    bit     typed;
    shown_t want;
  } offer_note_t;

  typedef struct packed {
    row_kind_e              kind;
    logic                   op;
    logic [CFG_IDX_W-1:0]   idx;
    logic [COLOR_W-1:0]     data;
    bit                     typed;
    logic [COLOR_W-1:0]     exp_color;
    logic                   exp_taken;
  } drill_row_t;

  drill_row_t drill [0:28] = '{
    '{ROW_ITEM,  OP_TICK,   CFG_FADE_DURATION,       24'hA5A5A5, 1'b1, 24'h000000, 1'b0},
    '{ROW_ITEM,  OP_TARGET, CFG_FADE_DURATION,       24'hFFFFFF, 1'b1, 24'h000000, 1'b0},
    '{ROW_WRITE, OP_TICK,   CFG_FADE_DURATION,       24'h000001, 1'b0, 24'h000000, 1'b0},
    '{ROW_WRITE, OP_TICK,   CFG_MIN_UPDATE_INTERVAL, 24'h000000, 1'b0, 24'h000000, 1'b0},
    '{ROW_ITEM,  OP_TARGET, CFG_FADE_DURATION,       24'hFFFFFF, 1'b1, 24'h000000, 1'b1},
    '{ROW_ITEM,  OP_TARGET, CFG_FADE_DURATION,       24'h123456, 1'b1, 24'h000000, 1'b0},
    '{ROW_ITEM,  OP_TICK,   CFG_FADE_DURATION,       24'h5A5A5A, 1'b1, 24'hFFFFFF, 1'b0},
    '{ROW_ITEM,  OP_TICK,   CFG_FADE_DURATION,       24'h000000, 1'b1, 24'hFFFFFF, 1'b0},
    '{ROW_ITEM,  OP_TARGET, CFG_FADE_DURATION,       24'h000000, 1'b1, 24'hFFFFFF, 1'b1},
    '{ROW_WRITE, OP_TICK,   CFG_FADE_DURATION,       24'h00FFFF, 1'b0, 24'h000000, 1'b0},
    '{ROW_ITEM,  OP_TICK,   CFG_FADE_DURATION,       24'hFFFFFF, 1'b1, 24'hFEFEFE, 1'b0},
    '{ROW_WRITE, OP_TICK,   CFG_MIN_UPDATE_INTERVAL, 24'h00FFFF, 1'b0, 24'h000000, 1'b0},
    '{ROW_ITEM,  OP_TARGET, CFG_FADE_DURATION,       24'hA53C0F, 1'b1, 24'hFEFEFE, 1'b0},
    '{ROW_WRITE, OP_TICK,   CFG_FADE_DURATION,       24'h000000, 1'b0, 24'h000000, 1'b0},
    '{ROW_WRITE, OP_TICK,   CFG_MIN_UPDATE_INTERVAL, 24'h000000, 1'b0, 24'h000000, 1'b0},
    '{ROW_ITEM,  OP_TICK,   CFG_FADE_DURATION,       24'h000000, 1'b1, 24'h000000, 1'b0},
    '{ROW_ITEM,  OP_TARGET, CFG_FADE_DURATION,       24'hFF00FF, 1'b1, 24'h000000, 1'b1},
    '{ROW_ITEM,  OP_TICK,   CFG_FADE_DURATION,       24'h00FF00, 1'b1, 24'hFF00FF, 1'b0},
    '{ROW_ITEM,  OP_TARGET, CFG_FADE_DURATION,       24'h00FF00, 1'b1, 24'hFF00FF, 1'b1},
    '{ROW_WRITE, OP_TICK,   CFG_FADE_DURATION,       24'h000003, 1'b0, 24'h000000, 1'b0},
    '{ROW_ITEM,  OP_TICK,   CFG_FADE_DURATION,       24'h000000, 1'b1, 24'hAA55AA, 1'b0},
    '{ROW_ITEM,  OP_TICK,   CFG_FADE_DURATION,       24'hFFFFFF, 1'b1, 24'h55AA55, 1'b0},
    '{ROW_ITEM,  OP_TICK,   CFG_FADE_DURATION,       24'h000000, 1'b1, 24'h00FF00, 1'b0},
    '{ROW_ITEM,  OP_TICK,   CFG_FADE_DURATION,       24'h000000, 1'b1, 24'h00FF00, 1'b0},
    '{ROW_ITEM,  OP_TARGET, CFG_FADE_DURATION,       24'h7F80C3, 1'b0, 24'h000000, 1'b0},
    '{ROW_WRITE, OP_TICK,   CFG_FADE_DURATION,       24'h000007, 1'b0, 24'h000000, 1'b0},
    '{ROW_ITEM,  OP_TICK,   CFG_FADE_DURATION,       24'h000000, 1'b0, 24'h000000, 1'b0},
    '{ROW_ITEM,  OP_TICK,   CFG_FADE_DURATION,       24'h3C3C3C, 1'b0, 24'h000000, 1'b0},
    '{ROW_ITEM,  OP_TICK,   CFG_FADE_DURATION,       24'hFFFFFF, 1'b0, 24'h000000, 1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tcf_req_if req_ch();
  tcf_res_if res_ch();

  timed_color_crossfader u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [DUR_W-1:0]     fade_len   = DUR_RESET;
  logic [DUR_W-1:0]     hold_off   = MIN_UPDATE_RESET;
  logic [COLOR_W-1:0]   from_color = '0;
  logic [COLOR_W-1:0]   to_color   = '0;
  logic [COLOR_W-1:0]   now_color  = '0;
  logic [ELAPSED_W-1:0] ticks      = '0;

  shown_t      expected_shown_q [$];
  offer_note_t offer_notes_q [$];
  int          requests_sent = 0;
  int          results_seen  = 0;
  int          fail_count    = 0;
  bit          gaps_on       = 1'b1;

  shown_t      want;
  offer_note_t note;

  function automatic logic [CHAN_W-1:0] blend(logic [CHAN_W-1:0] s, logic [CHAN_W-1:0] e,
                                              logic [ELAPSED_W-1:0] t, logic [DUR_W-1:0] d);
    longint num;
    num = longint'(s) * longint'(d) + (longint'(e) - longint'(s)) * longint'(t);
    if (num < 0) num = 0;
    return CHAN_W'(num / longint'(d));
  endfunction

  function automatic shown_t advance_fade(logic op, logic [COLOR_W-1:0] color);
    shown_t r;
    int     c;
    r.taken = 1'b0;
    if (op == OP_TICK) begin
      if (ticks != ELAPSED_MAX) ticks = ticks + 1'b1;
      if (fade_len == '0 || ticks > fade_len) begin
        now_color = to_color;
      end else begin
        for (c = 0; c < NUM_CHAN; c++)
          now_color[c*CHAN_W +: CHAN_W] = blend(from_color[c*CHAN_W +: CHAN_W],
                                                to_color[c*CHAN_W +: CHAN_W], ticks, fade_len);
      end
    end else if (ticks > hold_off) begin
      from_color = now_color;
      to_color   = color;
      ticks      = '0;
      r.taken    = 1'b1;
    end
    r.color = now_color;
    return r;
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  task automatic offer(logic op, logic [COLOR_W-1:0] color, bit typed, shown_t typed_want);
    int gap;
    gap = gaps_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    offer_notes_q.push_back('{typed, typed_want});
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= op;
    req_ch.target_color <= color;
    do @(posedge clk); while (!req_ch.ready);
    requests_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    req_ch.valid <= 1'b0;
    while (results_seen != requests_sent) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FADE_DURATION) fade_len = data;
    else hold_off = data;
  endtask

  // predict on request accept, check on result accept
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        note = offer_notes_q.pop_front();
        want = advance_fade(req_ch.operation, req_ch.target_color);
        if (note.typed) want = note.want;
        expected_shown_q.push_back(want);
      end
      if (res_ch.valid && res_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_shown_q.size() == 0) begin
          $display("%0t: unexpected result shown_color %06h target_taken %0b",
                   $time, res_ch.shown_color, res_ch.target_taken);
          fail_count++;
        end else begin
          want = expected_shown_q.pop_front();
          if (res_ch.shown_color !== want.color) begin
            $display("%0t: shown_color expected %06h actual %06h",
                     $time, want.color, res_ch.shown_color);
            fail_count++;
          end
          if (res_ch.target_taken !== want.taken) begin
            $display("%0t: target_taken expected %0b actual %0b",
                     $time, want.taken, res_ch.target_taken);
            fail_count++;
          end
        end
      end
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin
    int n;
    int accepted;
    accepted = 0;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      n = gaps_on ? $urandom_range(0, 16) : 0;
      if (accepted == HOLD_AT) n = HOLD_CYCLES;
      if (n > 0) begin
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      accepted++;
    end
  end

  initial begin
    int p;
    logic [DUR_W-1:0] dur;
    logic [DUR_W-1:0] gap_min;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.operation    <= OP_TICK;
    req_ch.target_color <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (drill[i]) begin
      if (drill[i].kind == ROW_WRITE)
        write_reg(drill[i].idx, drill[i].data[CFG_DATA_W-1:0]);
      else
        offer(drill[i].op, drill[i].data, drill[i].typed,
              '{drill[i].exp_color, drill[i].exp_taken});
    end

    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin dur = DUR_RESET; gap_min = MIN_UPDATE_RESET; end
        1: begin dur = 16'd1; gap_min = 16'd0; end
        2: begin dur = 16'hFFFF; gap_min = 16'd0; end
        3: begin
          dur     = DUR_W'($urandom_range(200, 65535));
          gap_min = DUR_W'($urandom_range(0, 40));
        end
        default: begin
          dur     = DUR_W'($urandom_range(1, 48));
          gap_min = DUR_W'($urandom_range(0, 6));
        end
      endcase
      write_reg(CFG_FADE_DURATION, dur);
      write_reg(CFG_MIN_UPDATE_INTERVAL, gap_min);
      gaps_on = (p != 3 && p != 6);
      repeat (PHASE_ITEMS)
        offer(($urandom_range(0, 4) == 0) ? OP_TARGET : OP_TICK, pick_color(), 1'b0, '0);
    end

    req_ch.valid <= 1'b0;
    while (results_seen != requests_sent) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && expected_shown_q.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/tcf_pkg.sv
hdl/tcf_req_if.sv
hdl/tcf_res_if.sv
hdl/timed_color_crossfader.sv
tb/tb_top.sv
